FILE: hw/rtl/longest_window_bounded_frequency_macros.svh
// ----------------------------------------------------------------------------
// Longest window bounded frequency: assertion macros
// Shared property wrappers used by the RTL files of this block.
// ----------------------------------------------------------------------------
`ifndef LONGEST_WINDOW_BOUNDED_FREQUENCY_MACROS_SVH
`define LONGEST_WINDOW_BOUNDED_FREQUENCY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LWBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LWBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lwbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest window bounded frequency: shared package
// Sizes, register index, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package lwbf_pkg;

    // Sequence storage and value alphabet.
    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 8;
    localparam int NUM_VALUES = 1 << VALUE_BITS;
    localparam int HIST_AW    = $clog2(MAX_LEN);
    localparam int POS_W      = $clog2(MAX_LEN + 1);
    localparam int CNT_W      = POS_W;

    // Fixed field widths of the stream and register interfaces.
    localparam int IN_VALUE_W = 8;
    localparam int OUT_LEN_W  = 11;
    localparam int MAXC_W     = 11;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [MAXC_W-1:0] MAX_COUNT_RESET = MAXC_W'(1);

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MAX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INC,
        S_HRD,
        S_CRD,
        S_DEC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic inc;
        logic hist_rd;
        logic cnt_rd;
        logic dec;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic over;
        logic more;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/longest_window_bounded_frequency.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest window bounded frequency: top level
// Streams values in and reports, for each one, the longest window ending
// there in which no value occurs more than max_count times, and the best so far.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tdata carries the value, tuser carries the first flag,
//   which starts a new sequence. Output stream m_*: tdata carries the window
//   length and best length, tuser the overflow flag. One result per request.
//   APB port: max_count at byte address 0, written while the block is idle.
// Timing:
//   A request passes through accept, count update and finish, plus a history
//   read, a count read and a decrement for every element evicted from the
//   left of the window; each element is evicted at most once. The eviction
//   loop is set by the registered history read followed by the registered
//   count read. Finish waits while the output register still holds a result.
// Reset: pointers, best length, overflow and count valid bits clear at once;
//   max_count returns to 1. History contents are not cleared.
// Stall: a result waits in the output register; the next request is accepted
//   meanwhile and its result waits in the controller until the register frees.
// ----------------------------------------------------------------------------
module longest_window_bounded_frequency (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lwbf_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] value
    input  logic [0:0]                    s_tuser,   // [0] first
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lwbf_pkg::M_DATA_W-1:0] m_tdata,   // [10:0] window_length,
                                                     // [21:11] best_length, rest zero
    output logic [0:0]                    m_tuser,   // [0] overflow
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lwbf_pkg::APB_AW-1:0]   paddr,
    input  logic [lwbf_pkg::APB_DW-1:0]   pwdata,
    output logic [lwbf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lwbf_pkg::*;

    logic [MAXC_W-1:0]    r_max_count;
    logic                 reg_wr;
    t_cmd                 cmd;
    t_status              status;
    logic [OUT_LEN_W-1:0] win_len;
    logic [OUT_LEN_W-1:0] best_len;
    logic                 ovf;

    // Configuration register.
    assign pready = 1'b1;
    assign reg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_MAX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= MAX_COUNT_RESET;
        end else if (reg_wr) begin
            r_max_count <= pwdata[MAXC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_COUNT) ? APB_DW'(r_max_count) : '0;

    // Controller.
    lwbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    lwbf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_value         (s_tdata[IN_VALUE_W-1:0]),
        .i_first         (s_tuser[0]),
        .i_max_count     (r_max_count),
        .i_out_ready     (m_tready),
        .o_out_valid     (m_tvalid),
        .o_window_length (win_len),
        .o_best_length   (best_len),
        .o_overflow      (ovf)
    );

    // Output packing.
    assign m_tdata = {(M_DATA_W - 2 * OUT_LEN_W)'(0), best_len, win_len};
    assign m_tuser = ovf;

endmodule

FILE: hw/rtl/lwbf_dp.sv
`timescale 1ns / 1ps
`include "longest_window_bounded_frequency_macros.svh"
// ----------------------------------------------------------------------------
// Longest window bounded frequency: datapath
// History memory, per-value count memory with valid bits, window pointers,
// best length and the output register.
// ----------------------------------------------------------------------------
module lwbf_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lwbf_pkg::t_cmd                  i_cmd,
    output lwbf_pkg::t_status               o_status,
    input  logic [lwbf_pkg::IN_VALUE_W-1:0] i_value,
    input  logic                            i_first,
    input  logic [lwbf_pkg::MAXC_W-1:0]     i_max_count,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [lwbf_pkg::OUT_LEN_W-1:0]  o_window_length,
    output logic [lwbf_pkg::OUT_LEN_W-1:0]  o_best_length,
    output logic                            o_overflow
);
    import lwbf_pkg::*;

    // Memories.
    logic [VALUE_BITS-1:0] hist_mem [MAX_LEN];
    logic [CNT_W-1:0]      cnt_mem  [NUM_VALUES];
    logic [NUM_VALUES-1:0] r_valid;

    // Sequence state.
    logic [VALUE_BITS-1:0] r_v;
    logic [VALUE_BITS-1:0] r_old;
    logic [POS_W-1:0]      r_left;
    logic [POS_W-1:0]      r_right;
    logic [POS_W-1:0]      r_best;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_cnt_v;

    // Registered memory read data.
    logic [VALUE_BITS-1:0] r_hist_q;
    logic [CNT_W-1:0]      r_cnt_q;
    logic                  r_cnt_vld_q;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_LEN_W-1:0]  r_out_win;
    logic [OUT_LEN_W-1:0]  r_out_best;
    logic                  r_out_ovf;

    logic [VALUE_BITS-1:0] in_v;
    logic [POS_W-1:0]      eff_right;
    logic                  eff_ovf;
    logic                  new_ovf;
    logic [CNT_W-1:0]      cnt_cur;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;
    logic [CNT_W-1:0]      cnt_v_after;
    logic [POS_W-1:0]      left_nxt;
    logic [POS_W-1:0]      win;
    logic [POS_W-1:0]      best_nxt;
    logic                  cnt_we;
    logic [VALUE_BITS-1:0] cnt_waddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic                  cnt_re;
    logic [VALUE_BITS-1:0] cnt_raddr;

    // Accept-time view of the sequence, with a first flag clearing it.
    assign in_v      = i_value[VALUE_BITS-1:0];
    assign eff_right = i_first ? '0 : r_right;
    assign eff_ovf   = i_first ? 1'b0 : r_ovf;
    assign new_ovf   = eff_ovf | (eff_right >= POS_W'(MAX_LEN));

    // Count arithmetic on the registered read data.
    assign cnt_cur     = r_cnt_vld_q ? r_cnt_q : '0;
    assign cnt_inc     = cnt_cur + CNT_W'(1);
    assign cnt_dec     = (cnt_cur == '0) ? '0 : cnt_cur - CNT_W'(1);
    assign cnt_v_after = (r_old == r_v) ? cnt_dec : r_cnt_v;
    assign left_nxt    = r_left + POS_W'(1);

    // Window length and best length at the end of an item.
    assign win      = r_ovf ? '0 : r_right - r_left;
    assign best_nxt = (!r_ovf && (win > r_best)) ? win : r_best;

    // Count memory port selection.
    assign cnt_we    = i_cmd.inc | i_cmd.dec;
    assign cnt_waddr = i_cmd.inc ? r_v : r_old;
    assign cnt_wdata = i_cmd.inc ? cnt_inc : cnt_dec;
    assign cnt_re    = i_cmd.accept | i_cmd.cnt_rd;
    assign cnt_raddr = i_cmd.accept ? in_v : r_hist_q;

    // Status toward the controller.
    always_comb begin
        o_status.ovf      = r_ovf;
        o_status.over     = cnt_inc > CNT_W'(i_max_count);
        o_status.more     = (cnt_v_after > CNT_W'(i_max_count)) && (left_nxt < r_right);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // History memory: written at accept, read at the left pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !new_ovf) begin
            hist_mem[eff_right[HIST_AW-1:0]] <= in_v;
        end
        if (i_cmd.hist_rd) begin
            r_hist_q <= hist_mem[r_left[HIST_AW-1:0]];
        end
    end

    // Count memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_q <= cnt_mem[cnt_raddr];
        end
    end

    // Valid bits stand in for clearing the count memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cnt_vld_q <= 1'b0;
        end else begin
            if (i_cmd.accept && i_first) begin
                r_valid <= '0;
            end else if (cnt_we) begin
                r_valid[cnt_waddr] <= 1'b1;
            end
            if (cnt_re) begin
                r_cnt_vld_q <= r_valid[cnt_raddr] & !(i_cmd.accept && i_first);
            end
        end
    end

    // Window pointers, best length and overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_ovf <= new_ovf;
                if (i_first) begin
                    r_left  <= '0;
                    r_right <= '0;
                    r_best  <= '0;
                end
            end
            if (i_cmd.inc) begin
                r_right <= r_right + POS_W'(1);
            end
            if (i_cmd.dec) begin
                r_left <= left_nxt;
            end
            if (i_cmd.finish) begin
                r_best <= best_nxt;
            end
        end
    end

    // Item value, evicted value and the running count of the item value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v <= in_v;
        end
        if (i_cmd.cnt_rd) begin
            r_old <= r_hist_q;
        end
        if (i_cmd.inc) begin
            r_cnt_v <= cnt_inc;
        end else if (i_cmd.dec) begin
            r_cnt_v <= cnt_v_after;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_win  <= OUT_LEN_W'(win);
            r_out_best <= OUT_LEN_W'(best_nxt);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_length = r_out_win;
    assign o_best_length   = r_out_best;
    assign o_overflow      = r_out_ovf;

    // The window never runs past its right end or the history size.
    `LWBF_ASSERT_NOW(a_left_le_right, 1'b1, r_left <= r_right, "left pointer passed right pointer")
    `LWBF_ASSERT_NOW(a_right_bound, 1'b1, r_right <= POS_W'(MAX_LEN), "right pointer beyond history")
    // A reported window never beats the reported best.
    `LWBF_ASSERT_NEXT(a_best_covers_win, i_cmd.finish,
        r_out_ovf || (r_out_win <= r_out_best), "window longer than best")

endmodule

FILE: hw/rtl/lwbf_ctrl.sv
`timescale 1ns / 1ps
`include "longest_window_bounded_frequency_macros.svh"
// ----------------------------------------------------------------------------
// Longest window bounded frequency: controller
// Sequences accept, count update, the eviction loop and result hand-off.
// ----------------------------------------------------------------------------
module lwbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lwbf_pkg::t_status i_status,
    output lwbf_pkg::t_cmd    o_cmd
);
    import lwbf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_INC;
                end
            end
            S_INC: begin
                if (i_status.ovf) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = i_status.over ? S_HRD : S_FIN;
                end
            end
            S_HRD: begin
                o_cmd.hist_rd = 1'b1;
                n_state       = S_CRD;
            end
            S_CRD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = i_status.more ? S_HRD : S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Every accepted request leads into the count update.
    `LWBF_ASSERT_NEXT(a_accept_to_inc, o_cmd.accept, r_state == S_INC, "accept did not reach update")
    // Eviction steps follow each other in order.
    `LWBF_ASSERT_NEXT(a_hrd_to_crd, r_state == S_HRD, r_state == S_CRD, "history read not followed")
    // A result is only handed off when the output register can take it.
    `LWBF_ASSERT_NOW(a_finish_free, o_cmd.finish, i_status.out_free, "result loaded over a held one")

endmodule
